>>> rtl/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants and types of the run-length encoder with decimal counts.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CMD_DEPTH      = 2;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // flags that travel with one run command from front to back
  typedef struct packed {
    logic done;
    logic last;
  } cmd_flags_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_DIGS,
    BK_BYTE
  } back_state_t;

endpackage

>>> rtl/rle_if.sv
// ----------------------------------------------------------------------------
// rle_in_if / rle_out_if
// Valid/ready channels for raw bytes in and encoded bytes out.
// ----------------------------------------------------------------------------
interface rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_done;
  logic       output_end;

  modport source (output valid, output out_byte, output item_done, output output_end,
                  input ready);
  modport sink   (input valid, input out_byte, input item_done, input output_end,
                  output ready);
endinterface

>>> rtl/rle_fifo.sv
// ----------------------------------------------------------------------------
// rle_fifo
// Short register queue of run commands between front and back.
// ----------------------------------------------------------------------------
module rle_fifo
  import rle_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/rle_front.sv
// ----------------------------------------------------------------------------
// rle_front
// Tracks the open run and queues a command for each run to be written out.
// ----------------------------------------------------------------------------
module rle_front
  import rle_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_stream_end,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [COUNT_BITS-1:0] q_len,
  output logic [7:0]            q_byte,
  output cmd_flags_t            q_flags
);

  logic [7:0]            run_val_r, run_val_nxt;
  logic [COUNT_BITS-1:0] run_len_r, run_len_nxt;
  logic                  run_open_r, run_open_nxt;
  logic                  pend_r, pend_nxt;
  logic [7:0]            pend_byte_r, pend_byte_nxt;
  logic                  acc;
  logic                  extend;
  logic [COUNT_BITS-1:0] new_len;

  assign in_ready = !pend_r && !q_full;
  assign acc      = in_valid && in_ready;
  assign extend   = !run_open_r ||
                    ((in_data_byte == run_val_r) && (run_len_r != '1));
  assign new_len  = run_open_r ? run_len_r + 1'b1 : COUNT_BITS'(1);

  always_comb begin
    run_val_nxt   = run_val_r;
    run_len_nxt   = run_len_r;
    run_open_nxt  = run_open_r;
    pend_nxt      = pend_r;
    pend_byte_nxt = pend_byte_r;
    q_push        = 1'b0;
    q_len         = run_len_r;
    q_byte        = run_val_r;
    q_flags       = '{done: 1'b0, last: 1'b0};
    if (pend_r) begin
      // flush the one-byte run left behind by a closing final word
      if (!q_full) begin
        q_push   = 1'b1;
        q_len    = COUNT_BITS'(1);
        q_byte   = pend_byte_r;
        q_flags  = '{done: 1'b1, last: 1'b1};
        pend_nxt = 1'b0;
      end
    end else if (acc) begin
      if (extend) begin
        if (in_stream_end) begin
          q_push       = 1'b1;
          q_len        = new_len;
          q_byte       = in_data_byte;
          q_flags      = '{done: 1'b1, last: 1'b1};
          run_open_nxt = 1'b0;
          run_len_nxt  = '0;
          run_val_nxt  = '0;
        end else begin
          run_open_nxt = 1'b1;
          run_len_nxt  = new_len;
          run_val_nxt  = in_data_byte;
        end
      end else begin
        // close the open run
        q_push  = 1'b1;
        q_flags = '{done: !in_stream_end, last: 1'b0};
        if (in_stream_end) begin
          pend_nxt      = 1'b1;
          pend_byte_nxt = in_data_byte;
          run_open_nxt  = 1'b0;
          run_len_nxt   = '0;
          run_val_nxt   = '0;
        end else begin
          run_open_nxt = 1'b1;
          run_len_nxt  = COUNT_BITS'(1);
          run_val_nxt  = in_data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_val_r  <= '0;
      run_len_r  <= '0;
      run_open_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      run_val_r  <= run_val_nxt;
      run_len_r  <= run_len_nxt;
      run_open_r <= run_open_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

>>> rtl/rle_back.sv
// ----------------------------------------------------------------------------
// rle_back
// Converts a run length to decimal (shift-add-3, one bit per cycle) and
// streams the digits and the run byte into the output register.
// ----------------------------------------------------------------------------
module rle_back
  import rle_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [COUNT_BITS-1:0] q_len,
  input  logic [7:0]            q_byte,
  input  cmd_flags_t            q_flags,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_item_done,
  output logic                  out_output_end
);

  localparam int NDIG = (COUNT_BITS * 30103 + 99999) / 100000;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(COUNT_BITS);
  localparam int IW   = $clog2(NDIG);

  back_state_t           state_r, state_nxt;
  logic [COUNT_BITS-1:0] bin_r, bin_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  started_r, started_nxt;
  logic [7:0]            byte_r, byte_nxt;
  cmd_flags_t            flags_r, flags_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [7:0]            obyte_r, obyte_nxt;
  logic                  odone_r, odone_nxt;
  logic                  oend_r, oend_nxt;

  logic                  slot_free;
  logic                  small_len;
  logic [BW-1:0]         bcd_adj;
  logic [3:0]            digit;
  logic                  skip;
  logic                  emit;

  assign slot_free = !ovalid_r || out_ready;
  assign small_len = (q_len < COUNT_BITS'(10));
  assign digit     = bcd_r[4 * idx_r +: 4];
  assign skip      = !started_r && (digit == 4'd0) && (idx_r != '0);
  assign q_pop     = (state_r == BK_IDLE) && !q_empty;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      bcd_adj[4 * d +: 4] = (bcd_r[4 * d +: 4] >= 4'd5) ? bcd_r[4 * d +: 4] + 4'd3
                                                       : bcd_r[4 * d +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = small_len ? BK_DIGS : BK_CONV;
        end
      end
      BK_CONV: begin
        if (cnt_r == CW'(COUNT_BITS - 1)) begin
          state_nxt = BK_DIGS;
        end
      end
      BK_DIGS: begin
        if (!skip && slot_free && (idx_r == '0)) begin
          state_nxt = BK_BYTE;
        end
      end
      BK_BYTE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    byte_nxt    = byte_r;
    flags_nxt   = flags_r;
    emit        = 1'b0;
    obyte_nxt   = obyte_r;
    odone_nxt   = odone_r;
    oend_nxt    = oend_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          byte_nxt    = q_byte;
          flags_nxt   = q_flags;
          started_nxt = 1'b0;
          cnt_nxt     = '0;
          bin_nxt     = q_len;
          if (small_len) begin
            bcd_nxt = BW'(q_len[3:0]);
            idx_nxt = '0;
          end else begin
            bcd_nxt = '0;
            idx_nxt = IW'(NDIG - 1);
          end
        end
      end
      BK_CONV: begin
        bcd_nxt = {bcd_adj[BW-2:0], bin_r[COUNT_BITS-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r + 1'b1;
      end
      BK_DIGS: begin
        if (skip) begin
          idx_nxt = idx_r - 1'b1;
        end else if (slot_free) begin
          emit        = 1'b1;
          obyte_nxt   = ASCII_ZERO | {4'd0, digit};
          odone_nxt   = 1'b0;
          oend_nxt    = 1'b0;
          started_nxt = 1'b1;
          if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      BK_BYTE: begin
        if (slot_free) begin
          emit      = 1'b1;
          obyte_nxt = byte_r;
          odone_nxt = flags_r.done;
          oend_nxt  = flags_r.last;
        end
      end
      default: ;
    endcase
    ovalid_nxt = emit ? 1'b1 : (ovalid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    started_r <= started_nxt;
    byte_r    <= byte_nxt;
    flags_r   <= flags_nxt;
    obyte_r   <= obyte_nxt;
    odone_r   <= odone_nxt;
    oend_r    <= oend_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_byte       = obyte_r;
  assign out_item_done  = odone_r;
  assign out_output_end = oend_r;

endmodule

>>> rtl/rle_decimal_count_encoder_unit.sv
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder_unit
// Run-length encoder that writes each run as its decimal count, then its byte.
// ----------------------------------------------------------------------------
// Bytes that extend a run are taken one per cycle while the command queue has
// room. Each run that closes is queued as a command; a final byte that also
// closes a run queues two and holds the input until the second is queued.
// The back end takes a command, runs the bit-serial binary-to-decimal
// converter when the count is ten or more (not below ten), skips leading zero
// digits, then writes each digit and the run byte, waiting while the output
// is not ready. That converter sets the sustained rate; a two-entry command
// queue lets the input keep running while a run is being written out, and a
// full queue stalls it.
module rle_decimal_count_encoder_unit
  import rle_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rle_in_if.sink    in_ch,
  rle_out_if.source out_ch
);

  localparam int QW = COUNT_BITS + 8 + $bits(cmd_flags_t);

  logic                  fifo_push;
  logic                  fifo_pop;
  logic                  fifo_full;
  logic                  fifo_empty;
  logic [COUNT_BITS-1:0] push_len;
  logic [7:0]            push_byte;
  cmd_flags_t            push_flags;
  logic [COUNT_BITS-1:0] pop_len;
  logic [7:0]            pop_byte;
  cmd_flags_t            pop_flags;
  logic [QW-1:0]         pop_data;

  rle_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data_byte  (in_ch.data_byte),
    .in_stream_end (in_ch.stream_end),
    .q_full        (fifo_full),
    .q_push        (fifo_push),
    .q_len         (push_len),
    .q_byte        (push_byte),
    .q_flags       (push_flags)
  );

  rle_fifo #(.WIDTH(QW), .DEPTH(CMD_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fifo_push),
    .wr_data ({push_len, push_byte, push_flags}),
    .pop     (fifo_pop),
    .rd_data (pop_data),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  assign {pop_len, pop_byte, pop_flags} = pop_data;

  rle_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (fifo_empty),
    .q_len          (pop_len),
    .q_byte         (pop_byte),
    .q_flags        (pop_flags),
    .q_pop          (fifo_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_item_done  (out_ch.item_done),
    .out_output_end (out_ch.output_end)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (!fifo_full || fifo_pop))
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from empty queue");

  a_end_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.output_end) |-> out_ch.item_done)
    else $error("stream end word without item done");
`endif

endmodule

>>> sim/rle_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_encoder_checker
// Watches both channels of the decimal-count run-length encoder, predicts the
// encoded words of every accepted raw byte and compares them in order.
// ----------------------------------------------------------------------------
module rle_encoder_checker
  import rle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rle_in_if    in_mon,
  rle_out_if   out_mon,
  output int   err_count,
  output int   words_waiting,
  output int   words_checked
);

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] LEN_SAT = '1;

  typedef struct packed {
    logic [7:0] value;
    logic       done;
    logic       eos;
  } enc_word_t;

  logic [7:0]     run_byte;
  logic [CNT_W-1:0] run_len;
  logic           run_live;
  enc_word_t      expected_q[$];
  enc_word_t      burst_q[$];

  // append count digits, most significant first, then the run byte
  task automatic append_run(input logic [CNT_W-1:0] len, input logic [7:0] b,
                            input logic tail);
    int unsigned v;
    logic [7:0]  digs[$];
    enc_word_t   w;
    v = len;
    do begin
      digs.push_front(ASCII_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) begin
      w.value = digs[i];
      w.done  = 1'b0;
      w.eos   = 1'b0;
      burst_q.push_back(w);
    end
    w.value = b;
    w.done  = 1'b0;
    w.eos   = tail;
    burst_q.push_back(w);
  endtask

  task automatic take_byte(input logic [7:0] b, input logic fin);
    enc_word_t w;
    burst_q.delete();
    if (!run_live) begin
      run_byte = b;
      run_len  = CNT_W'(1);
      run_live = 1'b1;
    end else if (b == run_byte && run_len != LEN_SAT) begin
      run_len = run_len + 1'b1;
    end else begin
      append_run(run_len, run_byte, 1'b0);
      run_byte = b;
      run_len  = CNT_W'(1);
    end
    if (fin) begin
      append_run(run_len, run_byte, 1'b1);
      run_live = 1'b0;
      run_len  = '0;
      run_byte = '0;
    end
    foreach (burst_q[i]) begin
      w = burst_q[i];
      w.done = (i == burst_q.size() - 1);
      expected_q.push_back(w);
    end
  endtask

  task automatic check_word(input logic [7:0] ob, input logic dn, input logic oe);
    enc_word_t w;
    words_checked++;
    if (expected_q.size() == 0) begin
      $error("out_byte: no word expected, got %h", ob);
      err_count++;
    end else begin
      w = expected_q.pop_front();
      if (w.value != ob) begin
        $error("out_byte: expected %h, got %h", w.value, ob);
        err_count++;
      end
      if (w.done != dn) begin
        $error("item_done: expected %b, got %b", w.done, dn);
        err_count++;
      end
      if (w.eos != oe) begin
        $error("output_end: expected %b, got %b", w.eos, oe);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      run_byte = '0;
      run_len  = '0;
      run_live = 1'b0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        take_byte(in_mon.data_byte, in_mon.stream_end);
      if (out_mon.valid && out_mon.ready)
        check_word(out_mon.out_byte, out_mon.item_done, out_mon.output_end);
    end
    words_waiting = expected_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives raw byte streams into the decimal-count run-length encoder: directed
// edge cases, a long output hold and random well-formed streams, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import rle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 220;
  localparam int LONG_HOLD      = 400;

  logic clk = 1'b0;
  logic rst_n;

  rle_in_if  in_ch();
  rle_out_if out_ch();

  int err_count;
  int words_waiting;
  int words_checked;
  int n_items;
  int n_streams;
  int idle_cycles;
  int stall_left;
  bit hold_req;

  always #10 clk = ~clk;

  rle_decimal_count_encoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rle_encoder_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .err_count     (err_count),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14)
      return $urandom_range(1, 3);
    else if (r < 19)
      return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int send_gap();
    if ($urandom_range(0, 1) == 0)
      return 0;
    return gap_len();
  endfunction

  function automatic int run_pick();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15)
      return $urandom_range(1, 3);
    else if (r < 19)
      return $urandom_range(4, 12);
    return $urandom_range(20, 110);
  endfunction

  task automatic push_word(input logic [7:0] b, input logic fin, input int gap);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.stream_end <= fin;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (fin)
      n_streams++;
    @(negedge clk);
  endtask

  task automatic drain_all();
    in_ch.valid <= 1'b0;
    wait (words_waiting == 0);
    @(negedge clk);
  endtask

  // result side: random stalls, steady stretches and one long hold
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = gap_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** rle_decimal_count_encoder_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int         k;
    int         r;
    int         n_runs;
    int         run_len;
    int         start_items;
    bit         paused;
    logic [7:0] rb;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.stream_end = 1'b0;
    hold_req         = 1'b0;
    idle_cycles      = 0;
    n_items          = 0;
    n_streams        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte streams at both byte extremes
    push_word(8'h00, 1'b1, send_gap());
    push_word(8'hFF, 1'b1, send_gap());
    // run closed by a new byte that is also final
    repeat (3) push_word(8'h41, 1'b0, send_gap());
    push_word(8'h42, 1'b1, send_gap());
    // alternating bytes
    push_word(8'h55, 1'b0, send_gap());
    push_word(8'hAA, 1'b0, send_gap());
    push_word(8'h55, 1'b1, send_gap());
    // two-digit count of a byte that looks like a digit
    repeat (12) push_word(8'h30, 1'b0, send_gap());
    push_word(8'h39, 1'b1, send_gap());
    // final byte that extends the open run
    push_word(8'h7F, 1'b0, send_gap());
    push_word(8'h7F, 1'b1, send_gap());
    drain_all();

    // hold the output while the input keeps closing runs
    hold_req = 1'b1;
    for (k = 0; k < 30; k++)
      push_word(8'(k * 37 + 3), k == 29, 0);
    drain_all();

    start_items = n_items;
    paused      = 1'b0;
    while (n_items - start_items < RANDOM_WORDS) begin
      if (!paused && n_items - start_items >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain_all();
      end
      if ($urandom_range(0, 9) == 0) begin
        push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), send_gap());
      end else begin
        n_runs = $urandom_range(1, 5);
        for (r = 0; r < n_runs; r++) begin
          rb      = 8'($urandom_range(0, 255));
          run_len = run_pick();
          for (k = 0; k < run_len; k++)
            push_word(rb, (r == n_runs - 1) && (k == run_len - 1), send_gap());
        end
      end
    end
    push_word(8'($urandom_range(0, 255)), 1'b1, send_gap());
    drain_all();
    repeat (40) @(posedge clk);

    $display("Covered %0d raw words in %0d streams: edge cases, random runs",
             n_items, n_streams);
    $display("and a %0d-cycle output hold; %0d encoded words checked, %0d mismatches.",
             LONG_HOLD, words_checked, err_count);
    if (err_count == 0 && words_waiting == 0)
      $display("** rle_decimal_count_encoder_unit: PASSED **");
    else
      $display("** rle_decimal_count_encoder_unit: FAILED **");
    $finish;
  end

endmodule
